// ===== rtl/kfifo_pkg.sv =====
// Shared types, constants and helper functions for the keyboard key FIFO device.
package kfifo_pkg;

   // Ring buffer geometry. One slot always stays free, so KEY_DEPTH-1 keys fit.
   localparam int KEY_DEPTH = 256;
   localparam int PTR_W     = $clog2(KEY_DEPTH);
   localparam int KEY_W     = 9;
   localparam int WORD_W    = 16;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(KEY_DEPTH - 1);

   // Action codes.
   localparam logic ACT_KEY = 1'b0;
   localparam logic ACT_CMD = 1'b1;

   // Processor command codes carried in register A.
   localparam logic [WORD_W-1:0] CMD_CLEAR   = 16'd0;
   localparam logic [WORD_W-1:0] CMD_POP     = 16'd1;
   localparam logic [WORD_W-1:0] CMD_NO_KEY  = 16'd2;
   localparam logic [WORD_W-1:0] CMD_SET_MSG = 16'd3;

   // Host key codes that are remapped on pop.
   localparam logic [KEY_W-1:0] HOST_BACKSPACE = 9'd263;
   localparam logic [KEY_W-1:0] HOST_DELETE    = 9'h07f;
   localparam logic [KEY_W-1:0] HOST_ENTER     = 9'd343;
   localparam logic [KEY_W-1:0] HOST_NEWLINE   = 9'd10;
   localparam logic [KEY_W-1:0] HOST_UP        = 9'd259;
   localparam logic [KEY_W-1:0] HOST_DOWN      = 9'd258;
   localparam logic [KEY_W-1:0] HOST_LEFT      = 9'd260;
   localparam logic [KEY_W-1:0] HOST_RIGHT     = 9'd261;

   // Processor-side key codes.
   localparam logic [WORD_W-1:0] DEV_BACKSPACE = 16'h0010;
   localparam logic [WORD_W-1:0] DEV_RETURN    = 16'h0011;
   localparam logic [WORD_W-1:0] DEV_UP        = 16'h0080;
   localparam logic [WORD_W-1:0] DEV_DOWN      = 16'h0081;
   localparam logic [WORD_W-1:0] DEV_LEFT      = 16'h0082;
   localparam logic [WORD_W-1:0] DEV_RIGHT     = 16'h0083;

   // Request beat.
   typedef struct packed {
      logic              action;
      logic [KEY_W-1:0]  key_code;
      logic [WORD_W-1:0] cmd_word;
      logic [WORD_W-1:0] arg_word;
   } kfifo_req_type;

   // Result beat.
   typedef struct packed {
      logic              key_taken;
      logic              irq_raise;
      logic [WORD_W-1:0] irq_message;
      logic              c_write;
      logic [WORD_W-1:0] c_value;
      logic              bad_command;
   } kfifo_rsp_type;

   // Status carried from the access stage to the result stage.
   typedef struct packed {
      logic              key_taken;
      logic              irq_raise;
      logic [WORD_W-1:0] irq_message;
      logic              c_write;
      logic              pop_hit;
      logic              bad_command;
   } kfifo_stage_type;

   // Advance a ring pointer with wrap at the last slot.
   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] pos);
      return (pos == PTR_LAST) ? '0 : pos + 1'b1;
   endfunction

   // Translate a host key code to the processor's key numbering.
   function automatic logic [WORD_W-1:0] remap_key(input logic [KEY_W-1:0] code);
      logic [WORD_W-1:0] result;
      case (code)
         HOST_BACKSPACE, HOST_DELETE: result = DEV_BACKSPACE;
         HOST_ENTER, HOST_NEWLINE:    result = DEV_RETURN;
         HOST_UP:                     result = DEV_UP;
         HOST_DOWN:                   result = DEV_DOWN;
         HOST_LEFT:                   result = DEV_LEFT;
         HOST_RIGHT:                  result = DEV_RIGHT;
         default:                     result = WORD_W'(code);
      endcase
      return result;
   endfunction

endpackage

// ===== rtl/keyboard_key_fifo_device.sv =====
// Keyboard key FIFO device: key ring buffer, pointer control and command decode.
// A result strobes after its accepted request beat passes the s1 and result registers.
// Throughput: one request per cycle; busy stays low, and the single key RAM
// port pair (one write, one registered read) serves every beat.
// Results cannot be stalled by the receiver, and none are ever dropped.
// Synchronous reset empties the buffer, zeros the message word and clears
// the pipeline; the key RAM contents are not cleared.
module keyboard_key_fifo_device
   import kfifo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  kfifo_req_type req_data,
   output logic          rsp_strobe,
   output kfifo_rsp_type rsp_data
);

   logic [PTR_W-1:0]  write_pos_ff, write_pos_in;
   logic [PTR_W-1:0]  read_pos_ff, read_pos_in;
   logic [WORD_W-1:0] irq_word_ff, irq_word_in;
   logic              s1_valid_ff;
   kfifo_stage_type   s1_ff, s1_in;
   logic              rsp_strobe_ff;
   kfifo_rsp_type     rsp_ff, rsp_in;

   logic              accept;
   logic [PTR_W-1:0]  write_next;
   logic              store_key;
   logic [KEY_W-1:0]  rd_key;

   // The pipeline takes a beat every cycle.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign write_next = next_pos(write_pos_ff);
   assign store_key  = accept && (req_data.action == ACT_KEY) && (write_next != read_pos_ff);

   // Decode the beat, update the pointers and message word.
   always_comb begin
      write_pos_in = write_pos_ff;
      read_pos_in  = read_pos_ff;
      irq_word_in  = irq_word_ff;
      s1_in        = '0;
      if (store_key) begin
         write_pos_in      = write_next;
         s1_in.key_taken   = 1'b1;
         s1_in.irq_raise   = (irq_word_ff != '0);
         s1_in.irq_message = irq_word_ff;
      end
      if (accept && (req_data.action == ACT_CMD)) begin
         case (req_data.cmd_word)
            CMD_CLEAR: begin
               write_pos_in = '0;
               read_pos_in  = '0;
            end
            CMD_POP: begin
               s1_in.c_write = 1'b1;
               if (read_pos_ff != write_pos_ff) begin
                  s1_in.pop_hit = 1'b1;
                  read_pos_in   = next_pos(read_pos_ff);
               end
            end
            CMD_NO_KEY: begin
               s1_in.c_write = 1'b1;
            end
            CMD_SET_MSG: begin
               irq_word_in = req_data.arg_word;
            end
            default: begin
               s1_in.bad_command = 1'b1;
            end
         endcase
      end
   end

   // Key storage.
   kfifo_ram #(
      .WIDTH (KEY_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (store_key),
      .wr_addr (write_pos_ff),
      .wr_data (req_data.key_code),
      .rd_en   (s1_in.pop_hit),
      .rd_addr (read_pos_ff),
      .rd_data (rd_key)
   );

   // Build the result beat once the popped key is out of the RAM.
   always_comb begin
      rsp_in             = '0;
      rsp_in.key_taken   = s1_ff.key_taken;
      rsp_in.irq_raise   = s1_ff.irq_raise;
      rsp_in.irq_message = s1_ff.irq_message;
      rsp_in.c_write     = s1_ff.c_write;
      rsp_in.c_value     = s1_ff.pop_hit ? remap_key(rd_key) : '0;
      rsp_in.bad_command = s1_ff.bad_command;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff  <= '0;
         read_pos_ff   <= '0;
         irq_word_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         write_pos_ff  <= write_pos_in;
         read_pos_ff   <= read_pos_in;
         irq_word_ff   <= irq_word_in;
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/kfifo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kfifo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kfifo_checker.sv =====
// Port-level checks for the keyboard key FIFO device, bound to the top level.
module kfifo_checker
   import kfifo_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input kfifo_req_type req_data,
   input logic          rsp_strobe,
   input kfifo_rsp_type rsp_data
);

   // Every accepted beat yields a result.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted request produced no result");

   // No result without a matching accepted request.
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a matching request");

   // A result reports at most one kind of outcome.
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot0({rsp_data.key_taken, rsp_data.c_write, rsp_data.bad_command}))
      else $error("result reports more than one outcome");

   // An interrupt only comes with a stored key and a nonzero message.
   a_irq_with_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.irq_raise) |->
         (rsp_data.key_taken && (rsp_data.irq_message != '0)))
      else $error("interrupt without stored key or message");

   // Key events never write register C or flag a bad command.
   a_key_no_c: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_data.action, 2) == ACT_KEY)) |->
         (!rsp_data.c_write && !rsp_data.bad_command))
      else $error("key event produced a command result");

endmodule

bind keyboard_key_fifo_device kfifo_checker u_kfifo_checker (.*);
